// ----- rtl/core/keyword_mixed_alphabet_builder_top_assert.svh -----
// Assertion macros for the keyword mixed-alphabet builder.
// Included by the top level; needs nothing else.
`ifndef KEYWORD_MIXED_ALPHABET_BUILDER_TOP_ASSERT_SVH
`define KEYWORD_MIXED_ALPHABET_BUILDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KMAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kmab assertion failed");

// Next-cycle implication, checked outside reset.
`define KMAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kmab assertion failed");

`endif

// ----- rtl/core/kmab_pkg.sv -----
// Types and constants for the keyword mixed-alphabet builder.
// No dependencies.
package kmab_pkg;

    localparam int unsigned ALPHA_COUNT = 26;
    localparam int unsigned IDX_W       = 5;

    localparam logic [IDX_W-1:0] LETTER_J_IDX = 5'd9;
    localparam logic [IDX_W-1:0] NO_OMIT      = 5'd26;
    localparam logic [IDX_W-1:0] LAST_IDX     = 5'd25;

    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [7:0] ASCII_UPPER_A = 8'd65;
    localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;
    localparam logic [6:0] LETTER_A      = 7'd65;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHAR  = 5'b00010,
        S_OMIT  = 5'b00100,
        S_FILL  = 5'b01000,
        S_FLUSH = 5'b10000
    } t_state;

    typedef struct packed {
        logic             is_letter;
        logic [IDX_W-1:0] idx;
        logic [6:0]       letter;
    } t_dec;

endpackage

// ----- rtl/core/kmab_if.sv -----
// Valid/ready channels for keyword characters and key letters.
// Depends on nothing.
interface kmab_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       has_char;
    logic       is_last;

    modport source (output valid, output char_code, output has_char, output is_last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input is_last,
                    output ready);
endinterface

interface kmab_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] letter;
    logic       letter_valid;
    logic       end_of_key;

    modport source (output valid, output letter, output letter_valid, output end_of_key,
                    input ready);
    modport sink   (input valid, input letter, input letter_valid, input end_of_key,
                    output ready);
endinterface

// ----- rtl/core/keyword_mixed_alphabet_builder_top.sv -----
// Keyword mixed-alphabet builder. Keyword characters enter one item at a time; each
// new letter (case folded, non-letters dropped) leaves as one result. An ordinary
// character is accepted, then decoded and tested against the seen mask. The item marked
// last also runs the fill: a single bit-test unit walks the 26-bit seen mask one
// letter per cycle unless the output is stalled, first to find the omitted letter (J
// when J is unseen, else the first unseen letter, if any) and then to emit the other
// unseen letters; the final result is then released with the end-of-key flag. The
// output is registered, so a result may wait while the block keeps working up to the
// next result.
module keyword_mixed_alphabet_builder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kmab_in_if.sink    i_in,
    kmab_out_if.source o_out
);

    kmab_pkg::t_state r_state, n_state;
    logic [kmab_pkg::ALPHA_COUNT-1:0] r_seen, n_seen;
    logic [kmab_pkg::IDX_W-1:0]       r_idx, n_idx;
    logic [kmab_pkg::IDX_W-1:0]       r_omit, n_omit;
    logic [7:0] r_code, n_code;
    logic       r_has, n_has;
    logic       r_last, n_last;
    logic       r_pend_vld, n_pend_vld;
    logic [6:0] r_pend_letter, n_pend_letter;
    logic       r_out_vld, n_out_vld;
    logic [6:0] r_out_letter, n_out_letter;
    logic       r_out_lv, n_out_lv;
    logic       r_out_eok, n_out_eok;

    kmab_pkg::t_dec dec;
    logic out_free;
    logic out_load;
    logic bit_hit;
    logic candidate;
    logic idx_end;
    logic char_new;
    logic key_finishing;
    logic key_release;
    logic marker_out;

    kmab_letter_dec u_dec (
        .i_char_code (r_code),
        .o_dec       (dec)
    );

    assign out_free  = !r_out_vld || o_out.ready;
    // shared unit: one seen-mask bit test per cycle
    assign bit_hit   = r_seen[r_idx];
    assign candidate = !bit_hit && (r_idx != r_omit);
    assign idx_end   = (r_idx == kmab_pkg::LAST_IDX);
    assign char_new  = r_has && dec.is_letter && !r_seen[dec.idx];

    always_comb begin
        n_state       = r_state;
        n_seen        = r_seen;
        n_idx         = r_idx;
        n_omit        = r_omit;
        n_code        = r_code;
        n_has         = r_has;
        n_last        = r_last;
        n_pend_vld    = r_pend_vld;
        n_pend_letter = r_pend_letter;
        out_load      = 1'b0;
        n_out_letter  = r_out_letter;
        n_out_lv      = r_out_lv;
        n_out_eok     = r_out_eok;

        case (r_state)
            kmab_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    n_code  = i_in.char_code;
                    n_has   = i_in.has_char;
                    n_last  = i_in.is_last;
                    n_state = kmab_pkg::S_CHAR;
                end
            end
            kmab_pkg::S_CHAR: begin
                if (!r_last) begin
                    if (char_new) begin
                        // hold until the output register frees up
                        if (out_free) begin
                            out_load          = 1'b1;
                            n_out_letter      = dec.letter;
                            n_out_lv          = 1'b1;
                            n_out_eok         = 1'b0;
                            n_seen[dec.idx]   = 1'b1;
                            n_state           = kmab_pkg::S_IDLE;
                        end
                    end else begin
                        n_state = kmab_pkg::S_IDLE;
                    end
                end else begin
                    // on the last item the letter may be the final one: park it
                    if (char_new) begin
                        n_seen[dec.idx] = 1'b1;
                        n_pend_vld      = 1'b1;
                        n_pend_letter   = dec.letter;
                    end
                    n_idx   = '0;
                    n_state = kmab_pkg::S_OMIT;
                end
            end
            kmab_pkg::S_OMIT: begin
                if (!r_seen[kmab_pkg::LETTER_J_IDX]) begin
                    n_omit  = kmab_pkg::LETTER_J_IDX;
                    n_idx   = '0;
                    n_state = kmab_pkg::S_FILL;
                end else if (!bit_hit) begin
                    n_omit  = r_idx;
                    n_idx   = '0;
                    n_state = kmab_pkg::S_FILL;
                end else if (idx_end) begin
                    n_omit  = kmab_pkg::NO_OMIT;
                    n_idx   = '0;
                    n_state = kmab_pkg::S_FILL;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            kmab_pkg::S_FILL: begin
                if (!(candidate && r_pend_vld && !out_free)) begin
                    if (candidate) begin
                        // push the parked letter out, park the new one
                        if (r_pend_vld) begin
                            out_load     = 1'b1;
                            n_out_letter = r_pend_letter;
                            n_out_lv     = 1'b1;
                            n_out_eok    = 1'b0;
                        end
                        n_pend_vld    = 1'b1;
                        n_pend_letter = kmab_pkg::LETTER_A + {2'b00, r_idx};
                    end
                    if (idx_end) begin
                        n_state = kmab_pkg::S_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            kmab_pkg::S_FLUSH: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_letter = r_pend_vld ? r_pend_letter : 7'd0;
                    n_out_lv     = r_pend_vld;
                    n_out_eok    = 1'b1;
                    n_seen       = '0;
                    n_pend_vld   = 1'b0;
                    n_state      = kmab_pkg::S_IDLE;
                end
            end
            default: begin
                n_state    = kmab_pkg::S_IDLE;
                n_pend_vld = 1'b0;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (o_out.ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= kmab_pkg::S_IDLE;
            r_seen     <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_seen     <= n_seen;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_omit        <= n_omit;
        r_code        <= n_code;
        r_has         <= n_has;
        r_last        <= n_last;
        r_pend_letter <= n_pend_letter;
        r_out_letter  <= n_out_letter;
        r_out_lv      <= n_out_lv;
        r_out_eok     <= n_out_eok;
    end

    assign i_in.ready         = (r_state == kmab_pkg::S_IDLE);
    assign o_out.valid        = r_out_vld;
    assign o_out.letter       = r_out_letter;
    assign o_out.letter_valid = r_out_lv;
    assign o_out.end_of_key   = r_out_eok;

    assign key_finishing = (r_state == kmab_pkg::S_OMIT) || (r_state == kmab_pkg::S_FILL) ||
                           (r_state == kmab_pkg::S_FLUSH);
    assign key_release   = (r_state == kmab_pkg::S_FLUSH) && out_free;
    assign marker_out    = r_out_vld && !r_out_lv;

`include "keyword_mixed_alphabet_builder_top_assert.svh"

    // a parked letter only exists while the key is being finished
    `KMAB_ASSERT_NOW(a_pend_in_fill, i_clk, i_rst_n, r_pend_vld, key_finishing)
    // the seen mask is empty once a key is released
    `KMAB_ASSERT_NEXT(a_seen_clear, i_clk, i_rst_n, key_release, (r_seen == '0 && i_in.ready))
    // the end marker carries no letter
    `KMAB_ASSERT_NOW(a_marker_zero, i_clk, i_rst_n, marker_out, (r_out_letter == 7'd0 && r_out_eok))

endmodule

// ----- rtl/core/kmab_letter_dec.sv -----
// Character decoder: folds lower case to upper case and classifies letters.
// Depends on kmab_pkg.
module kmab_letter_dec (
    input  logic [7:0]     i_char_code,
    output kmab_pkg::t_dec o_dec
);

    logic       is_lower;
    logic [7:0] folded;
    logic [7:0] offset;

    always_comb begin
        is_lower = (i_char_code >= kmab_pkg::ASCII_LOWER_A) &&
                   (i_char_code <= kmab_pkg::ASCII_LOWER_Z);
        folded   = is_lower ? (i_char_code - kmab_pkg::CASE_OFFSET) : i_char_code;
        offset   = folded - kmab_pkg::ASCII_UPPER_A;
        o_dec.is_letter = (folded >= kmab_pkg::ASCII_UPPER_A) &&
                          (folded <= kmab_pkg::ASCII_UPPER_Z);
        o_dec.idx    = offset[kmab_pkg::IDX_W-1:0];
        o_dec.letter = folded[6:0];
    end

endmodule
